### rtl/mlp_two_layer_sigmoid_inference_assert.svh
// assertion macros for the perceptron block
// used by the port checker, no other dependencies
`ifndef MLP_TWO_LAYER_SIGMOID_INFERENCE_ASSERT_SVH
`define MLP_TWO_LAYER_SIGMOID_INFERENCE_ASSERT_SVH
// property that holds on every clock edge outside reset
`define MLP_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked during reset as well
`define MLP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/mlp_pkg.sv
// shared types, constants and arithmetic helpers for the perceptron block
// no dependencies
package mlp_pkg;
   localparam int WORD_W   = 16;
   localparam int SCORE_W  = 13;
   localparam int ONE_Q12  = 4096;
   localparam int FRAC_W   = 12;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_INFER = 1'b1;

   typedef logic signed [WORD_W-1:0] word_type;

   // floor shift by 12, add bias, saturate to 16 bits signed
   function automatic word_type finish_sum(input logic signed [47:0] acc,
                                           input word_type bias);
      logic signed [47:0] s;
      s = (acc >>> FRAC_W) + 48'(bias);
      if (s > 48'sd32767) return 16'sh7fff;
      else if (s < -48'sd32768) return 16'sh8000;
      else return s[WORD_W-1:0];
   endfunction

   // plan piecewise-linear sigmoid, result in 0..4096
   function automatic logic [SCORE_W-1:0] plan_sigmoid(input word_type x);
      logic [16:0] a;
      logic [12:0] y;
      a = x[WORD_W-1] ? 17'(-{x[WORD_W-1], x}) : 17'({1'b0, x});
      if (a >= 17'd20480) y = 13'(ONE_Q12);
      else if (a >= 17'd9728) y = 13'(a >> 5) + 13'd3456;
      else if (a >= 17'd4096) y = 13'(a >> 3) + 13'd2560;
      else y = 13'(a >> 2) + 13'd2048;
      return x[WORD_W-1] ? 13'(ONE_Q12) - y : y;
   endfunction
endpackage

### rtl/mlp_cell.sv
// one neuron cell: registered products, then sum, bias, saturate and a registered sigmoid
// depends on mlp_pkg
module mlp_cell import mlp_pkg::*; #(
   parameter int FAN_IN = 4
) (
   input  logic                     clock,
   input  logic                     advance,
   input  word_type                 act_in [FAN_IN],
   input  word_type                 weight [FAN_IN],
   input  word_type                 bias,
   output logic [SCORE_W-1:0]       act_out
);
   logic signed [31:0] prod_ff [FAN_IN];
   logic signed [31:0] prod_in [FAN_IN];
   word_type           bias_ff;
   logic signed [47:0] acc;
   logic [SCORE_W-1:0] act_ff;
   logic [SCORE_W-1:0] act_in_q;

   // one multiplier per input, registered
   always_comb begin
      for (int k = 0; k < FAN_IN; k++) prod_in[k] = act_in[k] * weight[k];
   end

   // sum of products, finish and activation
   always_comb begin
      acc = '0;
      for (int k = 0; k < FAN_IN; k++) acc = acc + 48'(prod_ff[k]);
      act_in_q = plan_sigmoid(finish_sum(acc, bias_ff));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         bias_ff <= bias;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) act_ff <= act_in_q;
   end

   assign act_out = act_ff;
endmodule

### rtl/mlp_two_layer_sigmoid_inference.sv
// mlp_two_layer_sigmoid_inference: two-layer perceptron forward pass
// the top level holds the weight store and two rows of neuron cells
// Usage:
//  - req_ channel: command 0 loads weight_value at weight_index (0..22,
//    larger indexes ignored), command 1 runs the features through the net
//  - rsp_ channel: one transaction with two scores per inference transaction
//  - loads produce no response transaction
//  - pipeline of four stages: hidden products, hidden activation, output
//    products, output activation
//  - throughput is one transaction per cycle while the pipeline is not
//    stalled; a load offered in the cycle right after an accepted inference
//    waits, since the output row reads its weights when that inference
//    moves from the hidden activation into the output product stage
//  - a load takes effect for every inference accepted after it
//  - when rsp_stall is high and the output stage is full the whole pipeline
//    holds; req_stall follows from that hold and from a waiting load
//  - reset clears the weight store to zero and empties the pipeline
module mlp_two_layer_sigmoid_inference import mlp_pkg::*; #(
   parameter int INPUT_COUNT  = 4,
   parameter int HIDDEN_COUNT = 3,
   parameter int OUTPUT_COUNT = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  logic [4:0]          req_weight_index,
   input  logic signed [15:0]  req_weight_value,
   input  logic signed [15:0]  req_feature_0,
   input  logic signed [15:0]  req_feature_1,
   input  logic signed [15:0]  req_feature_2,
   input  logic signed [15:0]  req_feature_3,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SCORE_W-1:0]  rsp_score_0,
   output logic [SCORE_W-1:0]  rsp_score_1
);
   localparam int HO_BASE = INPUT_COUNT * HIDDEN_COUNT;
   localparam int HB_BASE = HO_BASE + HIDDEN_COUNT * OUTPUT_COUNT;
   localparam int OB_BASE = HB_BASE + HIDDEN_COUNT;
   localparam int DEPTH   = OB_BASE + OUTPUT_COUNT;
   localparam int STAGES  = 4;

   word_type   store_ff [DEPTH];
   logic [STAGES-1:0] vld_ff;
   logic       advance;
   word_type   feat [INPUT_COUNT];
   word_type   hid_act [HIDDEN_COUNT];
   word_type   hid_act_row [HIDDEN_COUNT];
   logic [SCORE_W-1:0] hid_out [HIDDEN_COUNT];
   logic [SCORE_W-1:0] out_act [OUTPUT_COUNT];

   // pipeline moves unless the last stage is full and stalled
   assign advance   = !(vld_ff[STAGES-1] && rsp_stall);
   // a load waits while an inference sits in the first stage, hidden products
   assign req_stall = !advance || (req_valid && req_command == CMD_LOAD && vld_ff[0]);

   // weight store, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) store_ff[k] <= '0;
      end else if (req_valid && !req_stall && req_command == CMD_LOAD) begin
         for (int k = 0; k < DEPTH; k++)
            if (32'(req_weight_index) == k) store_ff[k] <= req_weight_value;
      end
   end

   // valid bits for each stage
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance)
         vld_ff <= {vld_ff[STAGES-2:0], req_valid && req_command == CMD_INFER};
   end

   // feature vector, inputs beyond four read as zero
   always_comb begin
      for (int j = 0; j < INPUT_COUNT; j++) begin
         unique case (j)
            0: feat[j] = req_feature_0;
            1: feat[j] = req_feature_1;
            2: feat[j] = req_feature_2;
            3: feat[j] = req_feature_3;
            default: feat[j] = '0;
         endcase
      end
   end

   // hidden row of cells
   for (genvar i = 0; i < HIDDEN_COUNT; i++) begin : g_hid
      word_type w [INPUT_COUNT];
      for (genvar j = 0; j < INPUT_COUNT; j++) begin : g_w
         assign w[j] = store_ff[j*HIDDEN_COUNT+i];
      end
      mlp_cell #(.FAN_IN(INPUT_COUNT)) u_cell (
         .clock(clock), .advance(advance), .act_in(feat), .weight(w),
         .bias(store_ff[HB_BASE+i]), .act_out(hid_out[i]));
      assign hid_act[i] = word_type'({3'b000, hid_out[i]});
      assign hid_act_row[i] = hid_act[i];
   end

   // output row of cells
   for (genvar i = 0; i < OUTPUT_COUNT; i++) begin : g_out
      word_type w [HIDDEN_COUNT];
      for (genvar j = 0; j < HIDDEN_COUNT; j++) begin : g_w
         assign w[j] = store_ff[HO_BASE+j*OUTPUT_COUNT+i];
      end
      mlp_cell #(.FAN_IN(HIDDEN_COUNT)) u_cell (
         .clock(clock), .advance(advance), .act_in(hid_act_row), .weight(w),
         .bias(store_ff[OB_BASE+i]), .act_out(out_act[i]));
   end

   assign rsp_valid   = vld_ff[STAGES-1];
   assign rsp_score_0 = out_act[0];
   assign rsp_score_1 = (OUTPUT_COUNT > 1) ? out_act[OUTPUT_COUNT > 1 ? 1 : 0] : '0;
endmodule

### rtl/mlp_checker.sv
// port checker for the perceptron block, bound to the top level
// depends on mlp_pkg and the assertion macro header
`include "mlp_two_layer_sigmoid_inference_assert.svh"
module mlp_checker import mlp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_command,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [SCORE_W-1:0] rsp_score_0,
   input logic [SCORE_W-1:0] rsp_score_1
);
   `MLP_ASSERT_CLK(a_score0_range, clock, reset, rsp_valid |-> rsp_score_0 <= 13'd4096, "score_0 out of range")
   `MLP_ASSERT_CLK(a_score1_range, clock, reset, rsp_valid |-> rsp_score_1 <= 13'd4096, "score_1 out of range")
   `MLP_ASSERT_CLK(a_stall_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_score_0)), "stalled response changed")
   `MLP_ASSERT_CLK(a_infer_no_stall, clock, reset, (req_valid && req_command == CMD_INFER && !rsp_valid) |-> !req_stall, "inference stalled with empty output")
   `MLP_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "response right after reset")
endmodule

bind mlp_two_layer_sigmoid_inference mlp_checker u_mlp_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_command(req_command), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_score_0(rsp_score_0), .rsp_score_1(rsp_score_1));

### verif/tb_top.sv
// testbench for the two-layer sigmoid perceptron block
// checks each score pair against an in-bench fixed-point forward pass
// depends on mlp_pkg and mlp_two_layer_sigmoid_inference
`timescale 1ns / 1ps

module tb_top;
   import mlp_pkg::*;

   localparam int STORE_DEPTH = 23;
   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 12;

   typedef struct packed {
      logic [SCORE_W-1:0] score_0;
      logic [SCORE_W-1:0] score_1;
   } score_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = CMD_LOAD;
   logic [4:0] req_weight_index = '0;
   logic signed [15:0] req_weight_value = '0;
   logic signed [15:0] req_feature_0 = '0;
   logic signed [15:0] req_feature_1 = '0;
   logic signed [15:0] req_feature_2 = '0;
   logic signed [15:0] req_feature_3 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [SCORE_W-1:0] rsp_score_0;
   logic [SCORE_W-1:0] rsp_score_1;

   // bench copy of the weight store
   logic signed [15:0] net_weights [STORE_DEPTH];
   score_pair_type expected_scores [$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit timed_out = 1'b0;

   always #5 clock = ~clock;

   mlp_two_layer_sigmoid_inference i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_weight_index(req_weight_index),
      .req_weight_value(req_weight_value),
      .req_feature_0(req_feature_0), .req_feature_1(req_feature_1),
      .req_feature_2(req_feature_2), .req_feature_3(req_feature_3),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_score_0(rsp_score_0), .rsp_score_1(rsp_score_1)
   );

   // floor shift, bias add and 16-bit clamp
   function automatic int unit_sum(longint acc, int bias);
      longint s;
      s = (acc >>> 12) + longint'(bias);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return int'(s);
   endfunction

   // piecewise-linear sigmoid approximation
   function automatic int sigmoid_q12(int x);
      int mag;
      int y;
      mag = (x < 0) ? -x : x;
      if (mag >= 20480) y = 4096;
      else if (mag >= 9728) y = (mag >>> 5) + 3456;
      else if (mag >= 4096) y = (mag >>> 3) + 2560;
      else y = (mag >>> 2) + 2048;
      return (x < 0) ? 4096 - y : y;
   endfunction

   function automatic score_pair_type forward_pass(logic signed [15:0] f0,
         logic signed [15:0] f1, logic signed [15:0] f2, logic signed [15:0] f3);
      int feat [4];
      int hid [3];
      int sc [2];
      longint acc;
      score_pair_type r;
      feat[0] = f0; feat[1] = f1; feat[2] = f2; feat[3] = f3;
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 4; j++)
            acc += longint'(feat[j]) * longint'(net_weights[j*3+i]);
         hid[i] = sigmoid_q12(unit_sum(acc, net_weights[18+i]));
      end
      for (int i = 0; i < 2; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++)
            acc += longint'(hid[j]) * longint'(net_weights[12+j*2+i]);
         sc[i] = sigmoid_q12(unit_sum(acc, net_weights[21+i]));
      end
      r.score_0 = SCORE_W'(sc[0]);
      r.score_1 = SCORE_W'(sc[1]);
      return r;
   endfunction

   // send one transaction after a random gap, predict at acceptance
   task automatic send_item(logic cmd, logic [4:0] idx, logic signed [15:0] val,
         logic signed [15:0] f0, logic signed [15:0] f1,
         logic signed [15:0] f2, logic signed [15:0] f3, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_weight_index <= idx;
      req_weight_value <= val;
      req_feature_0 <= f0;
      req_feature_1 <= f1;
      req_feature_2 <= f2;
      req_feature_3 <= f3;
      do @(posedge clock); while (req_stall);
      if (cmd == CMD_LOAD) begin
         if (idx < STORE_DEPTH) net_weights[idx] = val;
      end else begin
         expected_scores.push_back(forward_pass(f0, f1, f2, f3));
      end
   endtask

   task automatic send_load(int idx, logic signed [15:0] val);
      send_item(CMD_LOAD, 5'(idx), val, 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom));
   endtask

   task automatic send_infer(logic signed [15:0] f0, logic signed [15:0] f1,
         logic signed [15:0] f2, logic signed [15:0] f3, bit no_gap = 0);
      send_item(CMD_INFER, 5'($urandom), 16'($urandom), f0, f1, f2, f3, no_gap);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_scores.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'($urandom_range(0, 8191));
         3: return -16'($urandom_range(0, 8191));
         default: return 16'($urandom);
      endcase
   endfunction

   // zero store, extreme features, out-of-range loads
   task automatic test_directed();
      send_infer(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
      send_infer(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
      send_load(31, 16'sh7fff);
      send_load(23, 16'sh8000);
      send_infer(16'sh1000, 16'sh1000, 16'sh1000, 16'sh1000);
      // saturating weights both ways
      for (int k = 0; k < STORE_DEPTH; k++)
         send_load(k, (k % 2) ? 16'sh8000 : 16'sh7fff);
      send_infer(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
      send_infer(16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff);
      wait_drained();
   endtask

   // sigmoid segment edges through a unit weight path
   task automatic test_sigmoid_segments();
      int pts [12] = '{0, 4095, 4096, 9727, 9728, 20479, 20480,
                       -4096, -9728, -20480, -20481, 32767};
      for (int k = 0; k < STORE_DEPTH; k++) send_load(k, 16'sh0000);
      send_load(0, 16'sh1000);
      send_load(12, 16'sh1000);
      send_load(13, 16'shf000);
      send_load(21, -16'sh0800);
      for (int k = 0; k < 12; k++)
         send_infer(16'(pts[k]), 16'($urandom), 16'($urandom), 16'($urandom));
      wait_drained();
   endtask

   // random weights and mixed traffic
   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0)
            send_load($urandom_range(0, 31), rand_word());
         else
            send_infer(rand_word(), rand_word(), rand_word(), rand_word());
      end
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int n = 0; n < 40; n++)
            send_infer(rand_word(), rand_word(), rand_word(), rand_word(), 1);
      join
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      score_pair_type exp_s;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_scores.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transaction: %0d %0d", rsp_score_0, rsp_score_1);
         end else begin
            exp_s = expected_scores.pop_front();
            if (exp_s.score_0 !== rsp_score_0 || exp_s.score_1 !== rsp_score_1) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("score mismatch: expected %0d %0d actual %0d %0d",
                           exp_s.score_0, exp_s.score_1, rsp_score_0, rsp_score_1);
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      int wait_left;
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (wait_left > 0) begin
         wait_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         wait_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
         rsp_stall <= (wait_left > 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles without a transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < STORE_DEPTH; k++) net_weights[k] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_sigmoid_segments();
      for (int k = 0; k < STORE_DEPTH; k++) send_load(k, rand_word());
      test_backpressure();
      test_random(1700);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && expected_scores.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end
endmodule
